[rtl/core/bvsm_pkg.sv]
// Shared types and constants of the binned voltage slope monitor.
`default_nettype none
package bvsm_pkg;

   localparam int unsigned MAX_BINS         = 4096;
   localparam int unsigned BIN_AW           = 12;
   localparam int unsigned SAMPLE_PERIOD_NS = 16666666;
   localparam int unsigned FILTER_SCALE     = 1024;
   localparam int unsigned NS_PER_MS        = 1000000;
   localparam int unsigned NV_PER_UV        = 1000;
   localparam int unsigned MV_PER_V_SCALE   = 1000;   // 1e9 ns/s over 1e6 ns/ms
   localparam int unsigned TALLY_MAX        = 4095;

   localparam int unsigned ACC_W   = 48;
   localparam int unsigned COUNT_W = 24;
   localparam int unsigned UV_W    = 27;
   localparam int unsigned DIV_DW  = 49;   // dividend / quotient width
   localparam int unsigned DIV_VW  = 36;   // divisor width

   // code * nV/LSB, then /1000 as ((x >> 3) * ceil(2^40 / 125)) >> 40
   localparam int unsigned PROD_W         = 36;
   localparam int unsigned UV_RECIP_SHIFT = 40;
   localparam int unsigned UV_PROD_W      = UV_RECIP_SHIFT + UV_W;
   localparam logic [33:0] UV_RECIP       = 34'd8796093023;

   localparam logic signed [31:0] NO_DATA_SLOPE = 32'sd9999999;

   localparam logic [1:0] OP_SAMPLE = 2'd0;
   localparam logic [1:0] OP_START  = 2'd1;
   localparam logic [1:0] OP_READ   = 2'd2;

   localparam logic [1:0] DIV_IDX   = 2'd1;
   localparam logic [1:0] DIV_AVG   = 2'd2;
   localparam logic [1:0] DIV_SLOPE = 2'd3;

   localparam logic [1:0] REG_BIN_WIDTH  = 2'd0;
   localparam logic [1:0] REG_BINS_USE   = 2'd1;
   localparam logic [1:0] REG_FLT_SHIFT  = 2'd2;
   localparam logic [1:0] REG_VOLT_SCALE = 2'd3;

   typedef struct packed {
      logic [15:0] width_ms;
      logic [12:0] bins_in_use;
      logic [3:0]  filter_shift;
      logic [19:0] volt_nv_per_lsb;
   } bvsm_cfg_type;

   typedef struct packed {
      logic       capture;
      logic       div_start;
      logic [1:0] div_sel;
      logic       uv_mul;
      logic       uv_scale;
      logic       uv_take;
      logic       idx_take;
      logic       clear_init;
      logic       clear_step;
      logic       bin_read;
      logic       bin_write;
      logic       load_read;
      logic       avg_take;
      logic       slope_take;
      logic       out_load;
   } bvsm_cmd_type;

   typedef struct packed {
      logic div_done;
      logic drop;
      logic clear_last;
      logic has_one;
      logic has_two;
   } bvsm_status_type;

endpackage
`default_nettype wire

[rtl/core/bvsm_csr.sv]
// Configuration registers behind the APB-style port.
`default_nettype none
module bvsm_csr
   import bvsm_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         csr_psel,
   input  wire logic         csr_penable,
   input  wire logic         csr_pwrite,
   input  wire logic [3:0]   csr_paddr,
   input  wire logic [31:0]  csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready,
   output bvsm_cfg_type      cfg
);

   bvsm_cfg_type cfg_ff, cfg_in;
   logic         wr_en;
   logic [1:0]   reg_idx;

   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = csr_paddr[3:2];
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_BIN_WIDTH:  cfg_in.width_ms        = csr_pwdata[15:0];
            REG_BINS_USE:   cfg_in.bins_in_use     = csr_pwdata[12:0];
            REG_FLT_SHIFT:  cfg_in.filter_shift    = csr_pwdata[3:0];
            REG_VOLT_SCALE: cfg_in.volt_nv_per_lsb = csr_pwdata[19:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_BIN_WIDTH:  csr_prdata = {16'd0, cfg_ff.width_ms};
         REG_BINS_USE:   csr_prdata = {19'd0, cfg_ff.bins_in_use};
         REG_FLT_SHIFT:  csr_prdata = {28'd0, cfg_ff.filter_shift};
         REG_VOLT_SCALE: csr_prdata = {12'd0, cfg_ff.volt_nv_per_lsb};
         default:        csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.width_ms        <= 16'd250;
         cfg_ff.bins_in_use     <= 13'd40;
         cfg_ff.filter_shift    <= 4'd2;
         cfg_ff.volt_nv_per_lsb <= 20'd78125;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

[rtl/core/bvsm_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none
module bvsm_div
   import bvsm_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [DIV_DW-1:0] dividend,
   input  wire logic [DIV_VW-1:0] divisor,
   output logic                   done,
   output logic [DIV_DW-1:0]      quotient
);

   localparam int unsigned CW = $clog2(DIV_DW);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [DIV_VW-1:0] rem_ff, rem_in;
   logic [DIV_DW-1:0] quo_ff, quo_in;
   logic [DIV_VW-1:0] dvs_ff, dvs_in;
   logic [DIV_VW:0]   trial;
   logic              ge;

   assign trial    = {rem_ff, quo_ff[DIV_DW-1]};
   assign ge       = trial >= {1'b0, dvs_ff};
   assign done     = done_ff;
   assign quotient = quo_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(DIV_DW - 1);
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so DIV_VW bits hold it
         rem_in = ge ? DIV_VW'(trial - {1'b0, dvs_ff}) : trial[DIV_VW-1:0];
         quo_in = {quo_ff[DIV_DW-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

endmodule
`default_nettype wire

[rtl/core/bvsm_datapath.sv]
// Datapath: filter, bin store, divider operand selection and result registers.
`default_nettype none
module bvsm_datapath
   import bvsm_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire bvsm_cfg_type       cfg,
   input  wire bvsm_cmd_type       cmd,
   output bvsm_status_type         status,
   input  wire logic [1:0]         req_operation,
   input  wire logic [15:0]        req_voltage_code,
   input  wire logic signed [15:0] req_current_code,
   input  wire logic [11:0]        req_bin_select,
   output logic signed [31:0]      rsp_slope_uv_per_s,
   output logic signed [15:0]      rsp_average_current,
   output logic [11:0]             rsp_bin_samples,
   output logic                    rsp_no_data
);

   // captured item
   logic [1:0]         op_ff;
   logic [15:0]        volt_ff;
   logic signed [15:0] cur_ff;
   logic [11:0]        sel_ff;

   // session state
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic               primed_ff;
   logic [COUNT_W-1:0] samples_ff;
   logic [BIN_AW-1:0]  clr_cnt_ff;
   logic [31:0]        smooth_ff, smooth_in;
   logic [DIV_DW-1:0]  idx_ff;

   // bin store
   logic [43:0]        mem_acc  [MAX_BINS];
   logic [63:0]        mem_volt [MAX_BINS];
   logic [BIN_AW-1:0]  rd_addr, wr_addr_ff;
   logic [43:0]        rd_acc_ff;
   logic [63:0]        rd_volt_ff;
   logic [11:0]        rd_tally;
   logic [31:0]        rd_total, rd_first, rd_last;
   logic [11:0]        new_tally;
   logic [31:0]        new_first, new_total;

   // readout
   logic [12:0]        active;
   logic               in_range;
   logic [11:0]        n_ff;
   logic               tot_neg_ff, dv_neg_ff;
   logic [31:0]        tot_mag_ff, dv_mag_ff;
   logic signed [32:0] dv;
   logic [15:0]        wms;

   // divider
   logic [DIV_DW-1:0]  div_a, div_q;
   logic [DIV_VW-1:0]  div_b;
   logic               div_done;

   // microvolt conversion
   logic [PROD_W-1:0]    prod_ff;
   logic [UV_PROD_W-1:0] uv_prod;
   logic [UV_W-1:0]      uv_ff;

   // filter
   logic [UV_W-1:0]    uv;
   logic [ACC_W-1:0]   scaled, acc_step;

   // output registers
   logic signed [31:0] avg_mag_sel;
   logic signed [31:0] slope_ff, slope_in;
   logic signed [15:0] avg_ff, avg_in;
   logic signed [31:0] out_slope_ff;
   logic signed [15:0] out_avg_ff;
   logic [11:0]        out_n_ff;
   logic               out_nd_ff;

   assign active   = (cfg.bins_in_use > 13'(MAX_BINS)) ? 13'(MAX_BINS) : cfg.bins_in_use;
   assign in_range = {1'b0, sel_ff} < active;
   assign wms      = (cfg.width_ms == 16'd0) ? 16'd1 : cfg.width_ms;

   assign rd_tally = rd_acc_ff[43:32];
   assign rd_total = rd_acc_ff[31:0];
   assign rd_first = rd_volt_ff[63:32];
   assign rd_last  = rd_volt_ff[31:0];
   assign dv       = $signed({1'b0, rd_last}) - $signed({1'b0, rd_first});

   assign status.div_done   = div_done;
   assign status.drop       = idx_ff >= DIV_DW'(active);
   assign status.clear_last = clr_cnt_ff == BIN_AW'(MAX_BINS - 1);
   assign status.has_one    = n_ff != 12'd0;
   assign status.has_two    = n_ff >= 12'd2;

   always_comb begin
      unique case (cmd.div_sel)
         DIV_IDX: begin
            div_a = DIV_DW'(samples_ff) * DIV_DW'(SAMPLE_PERIOD_NS);
            div_b = DIV_VW'(wms) * DIV_VW'(NS_PER_MS);
         end
         DIV_AVG: begin
            div_a = DIV_DW'(tot_mag_ff);
            div_b = DIV_VW'(n_ff);
         end
         DIV_SLOPE: begin
            div_a = DIV_DW'(dv_mag_ff) * DIV_DW'(MV_PER_V_SCALE);
            div_b = DIV_VW'(wms);
         end
         default: begin
            div_a = '0;
            div_b = '1;
         end
      endcase
   end

   bvsm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_a),
      .divisor  (div_b),
      .done     (div_done),
      .quotient (div_q)
   );

   // divide by 1000 as a shift by 3 and a reciprocal multiply for 125
   assign uv_prod = UV_PROD_W'(prod_ff[PROD_W-1:3]) * UV_PROD_W'(UV_RECIP);

   always_ff @(posedge clock) begin
      if (cmd.uv_mul)   prod_ff <= PROD_W'(volt_ff) * PROD_W'(cfg.volt_nv_per_lsb);
      if (cmd.uv_scale) uv_ff   <= uv_prod[UV_PROD_W-1 -: UV_W];
   end

   // moving-average filter, first sample of a session primes it
   assign uv       = uv_ff;
   assign scaled   = ACC_W'(uv) * ACC_W'(FILTER_SCALE);
   assign acc_step = acc_ff - (acc_ff >> cfg.filter_shift) + (scaled >> cfg.filter_shift);

   always_comb begin
      if (primed_ff) begin
         acc_in    = acc_step;
         smooth_in = 32'(acc_step / FILTER_SCALE);
      end else begin
         acc_in    = scaled;
         smooth_in = 32'(uv);
      end
   end

   assign rd_addr   = (op_ff == OP_READ) ? sel_ff : idx_ff[BIN_AW-1:0];
   assign new_tally = (rd_tally == 12'(TALLY_MAX)) ? rd_tally : rd_tally + 12'd1;
   assign new_first = (rd_tally == 12'd0) ? smooth_ff : rd_first;
   assign new_total = rd_total + 32'($signed(cur_ff));

   function automatic logic slope_take_pos_big();
      slope_take_pos_big = !dv_neg_ff && (div_q > DIV_DW'(32'h7FFFFFFF));
   endfunction

   always_comb begin
      if (slope_take_pos_big()) slope_in = 32'sh7FFFFFFF;
      else if (dv_neg_ff && div_q > DIV_DW'(33'h080000000)) slope_in = 32'sh80000000;
      else if (dv_neg_ff) slope_in = -$signed(div_q[31:0]);
      else slope_in = $signed(div_q[31:0]);
      avg_mag_sel = $signed(div_q[31:0]);
      avg_in      = tot_neg_ff ? 16'(-avg_mag_sel) : avg_mag_sel[15:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.bin_write) begin
         mem_acc[wr_addr_ff]  <= {new_tally, new_total};
      end else if (cmd.clear_step) begin
         mem_acc[clr_cnt_ff]  <= '0;
      end
      if (cmd.bin_read) begin
         rd_acc_ff <= mem_acc[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.bin_write) begin
         mem_volt[wr_addr_ff] <= {new_first, smooth_ff};
      end
      if (cmd.bin_read) begin
         rd_volt_ff <= mem_volt[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         primed_ff  <= 1'b0;
         samples_ff <= '0;
         clr_cnt_ff <= '0;
         acc_ff     <= '0;
      end else begin
         if (cmd.clear_init) begin
            primed_ff  <= 1'b0;
            samples_ff <= '0;
            clr_cnt_ff <= '0;
            acc_ff     <= '0;
         end else begin
            if (cmd.clear_step) clr_cnt_ff <= clr_cnt_ff + 1'b1;
            if (cmd.uv_take) begin
               acc_ff    <= acc_in;
               primed_ff <= 1'b1;
            end
            if (cmd.bin_write) samples_ff <= samples_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= req_operation;
         volt_ff <= req_voltage_code;
         cur_ff  <= req_current_code;
         sel_ff  <= req_bin_select;
      end
      if (cmd.uv_take)  smooth_ff <= smooth_in;
      if (cmd.idx_take) idx_ff    <= div_q;
      if (cmd.bin_read) wr_addr_ff <= rd_addr;
      if (cmd.load_read) begin
         n_ff       <= in_range ? rd_tally : 12'd0;
         tot_neg_ff <= rd_total[31];
         tot_mag_ff <= rd_total[31] ? 32'(-rd_total) : rd_total;
         dv_neg_ff  <= dv[32];
         dv_mag_ff  <= 32'(dv[32] ? -dv : dv);
         avg_ff     <= '0;
         slope_ff   <= NO_DATA_SLOPE;
      end
      if (cmd.avg_take)   avg_ff   <= avg_in;
      if (cmd.slope_take) slope_ff <= slope_in;
      if (cmd.out_load) begin
         out_slope_ff <= slope_ff;
         out_avg_ff   <= avg_ff;
         out_n_ff     <= n_ff;
         out_nd_ff    <= !status.has_two;
      end
   end

   assign rsp_slope_uv_per_s  = out_slope_ff;
   assign rsp_average_current = out_avg_ff;
   assign rsp_bin_samples     = out_n_ff;
   assign rsp_no_data         = out_nd_ff;

endmodule
`default_nettype wire

[rtl/core/bvsm_ctrl.sv]
// Controller: sequences the clear sweep, sample update and bin readout.
`default_nettype none
module bvsm_ctrl
   import bvsm_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic [1:0]       req_operation,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   input  wire bvsm_status_type  status,
   output bvsm_cmd_type          cmd
);

   localparam logic [3:0] S_CLEAR      = 4'd0;
   localparam logic [3:0] S_IDLE       = 4'd1;
   localparam logic [3:0] S_UV_MUL     = 4'd2;
   localparam logic [3:0] S_UV_SCALE   = 4'd3;
   localparam logic [3:0] S_IDX_GO     = 4'd4;
   localparam logic [3:0] S_IDX_WAIT   = 4'd5;
   localparam logic [3:0] S_BIN_RD     = 4'd6;
   localparam logic [3:0] S_BIN_WR     = 4'd7;
   localparam logic [3:0] S_RD_ADDR    = 4'd8;
   localparam logic [3:0] S_RD_LOAD    = 4'd9;
   localparam logic [3:0] S_AVG_GO     = 4'd10;
   localparam logic [3:0] S_AVG_WAIT   = 4'd11;
   localparam logic [3:0] S_SLOPE_GO   = 4'd12;
   localparam logic [3:0] S_SLOPE_WAIT = 4'd13;
   localparam logic [3:0] S_RESULT     = 4'd14;

   logic [3:0] state_ff, state_in;
   logic       valid_ff, valid_in;

   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      valid_in = valid_ff && rsp_stall;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               unique case (req_operation)
                  OP_SAMPLE: state_in = S_UV_MUL;
                  OP_START: begin
                     cmd.clear_init = 1'b1;
                     state_in       = S_CLEAR;
                  end
                  OP_READ: state_in = S_RD_ADDR;
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_UV_MUL: begin
            cmd.uv_mul = 1'b1;
            state_in   = S_UV_SCALE;
         end
         S_UV_SCALE: begin
            cmd.uv_scale = 1'b1;
            state_in     = S_IDX_GO;
         end
         // filter update runs beside the start of the bin index division
         S_IDX_GO: begin
            cmd.uv_take   = 1'b1;
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_IDX;
            state_in      = S_IDX_WAIT;
         end
         S_IDX_WAIT: begin
            if (status.div_done) begin
               cmd.idx_take = 1'b1;
               state_in     = S_BIN_RD;
            end
         end
         S_BIN_RD: begin
            if (status.drop) begin
               state_in = S_IDLE;
            end else begin
               cmd.bin_read = 1'b1;
               state_in     = S_BIN_WR;
            end
         end
         S_BIN_WR: begin
            cmd.bin_write = 1'b1;
            state_in      = S_IDLE;
         end
         S_RD_ADDR: begin
            cmd.bin_read = 1'b1;
            state_in     = S_RD_LOAD;
         end
         S_RD_LOAD: begin
            cmd.load_read = 1'b1;
            state_in      = S_AVG_GO;
         end
         S_AVG_GO: begin
            if (status.has_one) begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = DIV_AVG;
               state_in      = S_AVG_WAIT;
            end else begin
               state_in = S_SLOPE_GO;
            end
         end
         S_AVG_WAIT: begin
            cmd.div_sel = DIV_AVG;
            if (status.div_done) begin
               cmd.avg_take = 1'b1;
               state_in     = S_SLOPE_GO;
            end
         end
         S_SLOPE_GO: begin
            if (status.has_two) begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = DIV_SLOPE;
               state_in      = S_SLOPE_WAIT;
            end else begin
               state_in = S_RESULT;
            end
         end
         S_SLOPE_WAIT: begin
            cmd.div_sel = DIV_SLOPE;
            if (status.div_done) begin
               cmd.slope_take = 1'b1;
               state_in       = S_RESULT;
            end
         end
         S_RESULT: begin
            if (!valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               valid_in     = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

endmodule
`default_nettype wire

[rtl/core/binned_voltage_slope_monitor_top.sv]
// Top level of the binned voltage slope monitor.
// Items are taken one at a time. A sample item runs microvolt conversion by
// reciprocal multiply, a pass of the shared bit-serial divider for the bin
// index, then a bin read and write; a dropped sample skips the read and write.
// A read item makes up to two divider passes (average current, then slope)
// and takes longer while an earlier result still waits in the output register.
// A start item clears the bin counters and current sums in a sweep over all
// bins, one bin a cycle through the store's single write port; the same sweep
// runs after reset, and no item is taken until it ends. Configuration is to be
// written only while no item is in flight. A result sits in an output register,
// so the next item is taken while it waits.
`default_nettype none
module binned_voltage_slope_monitor_top
   import bvsm_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [1:0]         req_operation,
   input  wire logic [15:0]        req_voltage_code,
   input  wire logic signed [15:0] req_current_code,
   input  wire logic [11:0]        req_bin_select,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [31:0]      rsp_slope_uv_per_s,
   output logic signed [15:0]      rsp_average_current,
   output logic [11:0]             rsp_bin_samples,
   output logic                    rsp_no_data,
   input  wire logic               csr_psel,
   input  wire logic               csr_penable,
   input  wire logic               csr_pwrite,
   input  wire logic [3:0]         csr_paddr,
   input  wire logic [31:0]        csr_pwdata,
   output logic [31:0]             csr_prdata,
   output logic                    csr_pready
);

   bvsm_cfg_type    cfg;
   bvsm_cmd_type    cmd;
   bvsm_status_type status;

   bvsm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   bvsm_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .req_stall     (req_stall),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .status        (status),
      .cmd           (cmd)
   );

   bvsm_datapath u_dp (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg),
      .cmd                 (cmd),
      .status              (status),
      .req_operation       (req_operation),
      .req_voltage_code    (req_voltage_code),
      .req_current_code    (req_current_code),
      .req_bin_select      (req_bin_select),
      .rsp_slope_uv_per_s  (rsp_slope_uv_per_s),
      .rsp_average_current (rsp_average_current),
      .rsp_bin_samples     (rsp_bin_samples),
      .rsp_no_data         (rsp_no_data)
   );

endmodule
`default_nettype wire

[rtl/core/bvsm_checker.sv]
// Port-level checks of the slope monitor, bound to the top level.
`default_nettype none
module bvsm_props
   import bvsm_pkg::*;
(
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_stall,
   input wire logic               rsp_valid,
   input wire logic               rsp_stall,
   input wire logic signed [31:0] rsp_slope_uv_per_s,
   input wire logic [11:0]        rsp_bin_samples,
   input wire logic               rsp_no_data
);

   // a waiting result is not withdrawn
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result item dropped while stalled");

   a_nodata_slope: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_no_data |-> rsp_slope_uv_per_s == NO_DATA_SLOPE)
      else $error("empty bin without marker slope");

   a_nodata_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_no_data == (rsp_bin_samples < 12'd2)))
      else $error("no_data disagrees with sample count");

   // clear sweep blocks items right after reset
   a_reset_sweep: assert property (@(posedge clock)
      reset |=> req_stall && !rsp_valid)
      else $error("item channel open right after reset");

endmodule

bind binned_voltage_slope_monitor_top bvsm_props u_bvsm_props (.*);
`default_nettype wire

[test/bvsm_checker.sv]
// Checker for the binned voltage slope monitor: watches both channels, predicts, compares.
`default_nettype none
module bvsm_checker
   import bvsm_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic               req_stall,
   input  wire logic [1:0]         req_operation,
   input  wire logic [15:0]        req_voltage_code,
   input  wire logic signed [15:0] req_current_code,
   input  wire logic [11:0]        req_bin_select,
   input  wire logic               rsp_valid,
   input  wire logic               rsp_stall,
   input  wire logic signed [31:0] rsp_slope_uv_per_s,
   input  wire logic signed [15:0] rsp_average_current,
   input  wire logic [11:0]        rsp_bin_samples,
   input  wire logic               rsp_no_data,
   input  wire logic               csr_psel,
   input  wire logic               csr_penable,
   input  wire logic               csr_pwrite,
   input  wire logic [3:0]         csr_paddr,
   input  wire logic [31:0]        csr_pwdata,
   input  wire logic               csr_pready,
   output int                      errors,
   output int                      outstanding,
   output int                      reads_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic signed [31:0] slope;
      logic signed [15:0] avg;
      logic [11:0]        count;
      logic               empty;
   } bin_report_type;

   bin_report_type expected_reports[$];
   int pushed = 0;
   int popped = 0;
   assign outstanding = pushed - popped;
   assign reads_checked = popped;

   // configuration copy
   logic [15:0] width_ms = 16'd250;
   logic [12:0] bins_cfg = 13'd40;
   logic [3:0]  shift = 4'd2;
   logic [19:0] nv_per_code = 20'd78125;

   // session state
   logic [47:0] acc;
   logic        primed;
   logic [23:0] taken;
   logic [31:0] first_uv [MAX_BINS];
   logic [31:0] last_uv [MAX_BINS];
   logic [31:0] cur_total [MAX_BINS];
   logic [11:0] tally [MAX_BINS];

   initial errors = 0;

   task automatic report(input string what, input longint got, input longint want);
      $display("mismatch %0t: %s got %0d expected %0d", $realtime, what, got, want);
      errors++;
   endtask

   function automatic longint unsigned bin_ns();
      return (width_ms == 0 ? 64'd1 : 64'(width_ms)) * NS_PER_MS;
   endfunction

   function automatic int unsigned live_bins();
      return bins_cfg > MAX_BINS ? MAX_BINS : bins_cfg;
   endfunction

   task automatic clear_session();
      acc = '0;
      primed = 1'b0;
      taken = '0;
      for (int i = 0; i < MAX_BINS; i++) begin
         first_uv[i] = '0;
         last_uv[i] = '0;
         cur_total[i] = '0;
         tally[i] = '0;
      end
   endtask

   task automatic take_sample(input logic [15:0] code, input logic signed [15:0] cur);
      longint unsigned uv, scaled, idx;
      logic [31:0] v;
      int unsigned b;
      uv = 64'(code) * 64'(nv_per_code) / NV_PER_UV;
      scaled = uv * FILTER_SCALE;
      if (!primed) begin
         acc = scaled[47:0];
         primed = 1'b1;
         v = uv[31:0];
      end else begin
         acc = acc - (acc >> shift) + 48'(scaled >> shift);
         v = 32'(64'(acc) / FILTER_SCALE);
      end
      idx = 64'(taken) * SAMPLE_PERIOD_NS / bin_ns();
      if (idx < live_bins()) begin
         b = 32'(idx);
         if (tally[b] == 0) first_uv[b] = v;
         last_uv[b] = v;
         cur_total[b] = cur_total[b] + 32'(cur);
         if (tally[b] < TALLY_MAX) tally[b]++;
         taken = taken + 24'd1;
      end
   endtask

   function automatic bin_report_type read_bin(input logic [11:0] sel);
      bin_report_type r;
      longint dv, sl;
      r.slope = NO_DATA_SLOPE;
      r.avg = '0;
      r.count = '0;
      r.empty = 1'b1;
      if (sel < live_bins()) begin
         r.count = tally[sel];
         if (tally[sel] > 0)
            r.avg = 16'(longint'(signed'(cur_total[sel])) / longint'(tally[sel]));
         if (tally[sel] >= 2) begin
            dv = longint'(last_uv[sel]) - longint'(first_uv[sel]);
            sl = dv * 64'sd1000000000 / longint'(bin_ns());
            if (sl > 64'sd2147483647) sl = 64'sd2147483647;
            if (sl < -64'sd2147483648) sl = -64'sd2147483648;
            r.slope = 32'(sl);
            r.empty = 1'b0;
         end
      end
      return r;
   endfunction

   initial clear_session();

   always @(posedge clock) begin
      bin_report_type want;
      if (!reset) begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[3:2])
               REG_BIN_WIDTH:  width_ms = csr_pwdata[15:0];
               REG_BINS_USE:   bins_cfg = csr_pwdata[12:0];
               REG_FLT_SHIFT:  shift = csr_pwdata[3:0];
               REG_VOLT_SCALE: nv_per_code = csr_pwdata[19:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_reports.size() == 0) begin
               report("unexpected result", rsp_slope_uv_per_s, 0);
            end else begin
               want = expected_reports.pop_front();
               popped++;
               if (rsp_slope_uv_per_s !== want.slope)
                  report("slope", rsp_slope_uv_per_s, want.slope);
               if (rsp_average_current !== want.avg)
                  report("average current", rsp_average_current, want.avg);
               if (rsp_bin_samples !== want.count)
                  report("bin samples", rsp_bin_samples, want.count);
               if (rsp_no_data !== want.empty)
                  report("no data", rsp_no_data, want.empty);
            end
         end
         if (req_valid && !req_stall) begin
            case (req_operation)
               OP_SAMPLE: take_sample(req_voltage_code, req_current_code);
               OP_START:  clear_session();
               OP_READ: begin
                  expected_reports.push_back(read_bin(req_bin_select));
                  pushed++;
               end
               default: ;
            endcase
         end
      end
   end
endmodule
`default_nettype wire

[test/binned_voltage_slope_monitor_top_tb.sv]
// Testbench top: stimulus, idling, configuration phases and verdict.
`default_nettype none
module binned_voltage_slope_monitor_top_tb;
   import bvsm_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 3000000;
   localparam int PHASE_ITEMS = 180;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_operation = OP_SAMPLE;
   logic [15:0] req_voltage_code = '0;
   logic signed [15:0] req_current_code = '0;
   logic [11:0] req_bin_select = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [31:0] rsp_slope_uv_per_s;
   logic signed [15:0] rsp_average_current;
   logic [11:0] rsp_bin_samples;
   logic rsp_no_data;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [3:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   int errors, outstanding, reads_checked;
   int tx_idle_pct = 11;
   int rx_idle_pct = 82;
   int items_sent = 0;
   int cycles = 0;
   int unsigned cur_bins = 40;

   binned_voltage_slope_monitor_top uut (.*);

   bvsm_checker u_checker (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("binned_voltage_slope_monitor_top_tb NOT OK");
         $finish;
      end
   end

   always @(negedge clock) rsp_stall <= ($urandom_range(99) < rx_idle_pct);

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] value);
      @(negedge clock);
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite = 1'b1;
      csr_paddr = {idx, 2'b00};
      csr_pwdata = value;
      @(negedge clock);
      csr_penable = 1'b1;
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
   endtask

   task automatic send(input logic [1:0] op, input logic [15:0] v, input logic [15:0] c,
                       input logic [11:0] sel);
      while ($urandom_range(99) < tx_idle_pct) begin
         @(negedge clock);
         req_valid = 1'b0;
      end
      @(negedge clock);
      req_valid = 1'b1;
      req_operation = op;
      req_voltage_code = v;
      req_current_code = c;
      req_bin_select = sel;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   // idle point for register writes: all results in, then room for a clear sweep
   task automatic settle();
      @(negedge clock);
      req_valid = 1'b0;
      while (outstanding != 0) @(posedge clock);
      repeat (4300) @(posedge clock);
   endtask

   task automatic configure(input int w, input int b, input int s, input int nv);
      settle();
      csr_write(REG_BIN_WIDTH, w);
      csr_write(REG_BINS_USE, b);
      csr_write(REG_FLT_SHIFT, s);
      csr_write(REG_VOLT_SCALE, nv);
      cur_bins = b > MAX_BINS ? MAX_BINS : b;
   endtask

   task automatic random_item();
      int unsigned pick, span;
      logic [15:0] v;
      pick = $urandom_range(99);
      span = cur_bins == 0 ? 1 : (cur_bins > 48 ? 48 : cur_bins);
      // voltage mostly drifts in a band so slopes stay meaningful
      v = ($urandom_range(3) == 0) ? 16'($urandom) : 16'(30000 + $urandom_range(2000));
      if (pick < 3)
         send(OP_START, 16'($urandom), 16'($urandom), 12'($urandom));
      else if (pick < 75)
         send(OP_SAMPLE, v, 16'($urandom), 12'($urandom));
      else if (pick < 97)
         send(OP_READ, 16'($urandom), 16'($urandom),
              ($urandom_range(4) == 0) ? 12'($urandom) : 12'($urandom_range(span - 1)));
      else
         send(2'd3, 16'($urandom), 16'($urandom), 12'($urandom));
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty reads, unknown op, field extremes
      send(OP_READ, 16'h0000, 16'h0000, 12'd0);
      send(OP_READ, 16'hffff, 16'hffff, 12'd4095);
      send(2'd3, 16'hffff, 16'h8000, 12'hfff);
      send(OP_SAMPLE, 16'hffff, 16'sh7fff, 12'h000);
      send(OP_READ, 16'h0, 16'h0, 12'd0);
      send(OP_SAMPLE, 16'h0000, -16'sh8000, 12'hfff);
      send(OP_SAMPLE, 16'hffff, -16'sh8000, 12'h000);
      send(OP_SAMPLE, 16'h0000, 16'sh7fff, 12'h000);
      send(OP_READ, 16'h0, 16'h0, 12'd0);
      send(OP_READ, 16'h0, 16'h0, 12'd39);
      send(OP_READ, 16'h0, 16'h0, 12'd40);
      send(OP_START, 16'h0, 16'h0, 12'h0);
      send(OP_READ, 16'h0, 16'h0, 12'd0);
      configure(0, 8191, 10, 1000000);   // zero width, too many bins, shift of 10
      send(OP_START, 16'h0, 16'h0, 12'h0);
      for (int i = 0; i < 4; i++) send(OP_SAMPLE, 16'($urandom), 16'($urandom), 12'h0);
      send(OP_READ, 16'h0, 16'h0, 12'd4095);
      send(OP_READ, 16'h0, 16'h0, 12'd0);
      send(OP_READ, 16'h0, 16'h0, 12'd1);
      configure(1000, 0, 3, 500000);     // zero bins drops every sample
      send(OP_SAMPLE, 16'h1234, 16'h0042, 12'h0);
      send(OP_READ, 16'h0, 16'h0, 12'd0);

      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: configure(250, 40, 2, 78125);
            1: configure(100, 5, 0, 1000000);
            2: configure(60000, 1, 10, 1);
            3: configure(100, 4096, 1, 78125);
            4: configure(65535, 2, 7, 333333);
            default: configure(500, 12, 4, 250000);
         endcase
         if (ph == 2) begin
            tx_idle_pct = 82;
            rx_idle_pct = 11;
         end else if (ph == 4) begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
         send(OP_START, 16'h0, 16'h0, 12'h0);
         for (int i = 0; i < PHASE_ITEMS; i++) random_item();
      end

      @(negedge clock);
      req_valid = 1'b0;
      while (outstanding != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("sent %0d items over 8 register settings, %0d bin reads checked",
               items_sent, reads_checked);
      if (errors == 0 && outstanding == 0)
         $display("binned_voltage_slope_monitor_top_tb OK");
      else
         $display("binned_voltage_slope_monitor_top_tb NOT OK");
      $finish;
   end
endmodule
`default_nettype wire
